### sv/ttu_pkg.sv
// Shared types, constants and character tables for the text to UTF-8 transcoder.
`timescale 1ns / 1ps
`default_nettype none

package ttu_pkg;

	localparam int MAX_CAPACITY = 4096;
	localparam int CAP_W        = 13;
	localparam int COUNT_W      = 12;
	localparam int RES_DEPTH    = 7;
	localparam int RES_CNT_W    = 3;
	localparam int CFG_IDX_W    = 1;

	localparam logic [CAP_W-1:0] CAP_LIMIT = CAP_W'(MAX_CAPACITY);
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_MODE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_CAPACITY = 1'b1;

	// Byte order marks
	localparam logic [7:0] BOM_FF = 8'hFF;
	localparam logic [7:0] BOM_FE = 8'hFE;

	// Code points and surrogate arithmetic
	localparam logic [15:0] CYR_BASE       = 16'h0410;
	localparam logic [20:0] HIGH_SURR_BASE = 21'h00D800;
	localparam logic [20:0] SUPP_BASE      = 21'h010000;
	localparam logic [5:0]  HIGH_SURR_TAG  = 6'b110110;
	localparam logic [5:0]  LOW_SURR_TAG   = 6'b110111;

	typedef enum logic [2:0] {
		ENC_LATIN1  = 3'd0,
		ENC_UTF16   = 3'd1,
		ENC_UTF16BE = 3'd2,
		ENC_UTF8    = 3'd3,
		ENC_NONE    = 3'd4,
		ENC_CP1251  = 3'd5
	} ttu_enc_t;

	typedef enum logic [1:0] {
		PH_START = 2'd0,
		PH_BOM1  = 2'd1,
		PH_BOM2  = 2'd2,
		PH_BODY  = 2'd3
	} ttu_phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       has_byte;
		logic       last;
	} ttu_item_t;

	// One encoded character: bytes[0] goes out first
	typedef struct packed {
		logic            ok;
		logic [2:0]      n;
		logic [3:0][7:0] bytes;
	} ttu_char_t;

	// Every word that one input item produces, in order
	typedef struct packed {
		logic [RES_DEPTH-1:0][7:0] bytes;
		logic [RES_CNT_W-1:0]      count;
		logic                      term;
		logic [COUNT_W-1:0]        byte_count;
	} ttu_res_t;

	localparam logic [31:0][15:0] CP1251_HIGH = {
		16'h045F, 16'h045B, 16'h045C, 16'h045A, 16'h203A, 16'h0459, 16'h2122, 16'h0098,
		16'h2014, 16'h2013, 16'h2022, 16'h201D, 16'h201C, 16'h2019, 16'h2018, 16'h0452,
		16'h040F, 16'h040B, 16'h040C, 16'h040A, 16'h2039, 16'h0409, 16'h2030, 16'h20AC,
		16'h2021, 16'h2020, 16'h2026, 16'h201E, 16'h0453, 16'h201A, 16'h0403, 16'h0402
	};

	function automatic logic [15:0] cp1251_map(input logic [7:0] c);
		logic [15:0] r;
		if (c[7] == 1'b0) begin
			r = {8'h00, c};
		end else if (c[7:6] == 2'b11) begin
			r = CYR_BASE + {10'b0, c[5:0]};
		end else if (c[5] == 1'b0) begin
			r = CP1251_HIGH[c[4:0]];
		end else begin
			// 0xA0..0xBF map onto themselves
			r = {8'h00, c};
		end
		return r;
	endfunction

	function automatic logic [2:0] utf8_len(input logic [20:0] cp);
		logic [2:0] n;
		if (cp <= 21'h00007F) begin
			n = 3'd1;
		end else if (cp <= 21'h0007FF) begin
			n = 3'd2;
		end else if (cp <= 21'h00FFFF) begin
			n = 3'd3;
		end else begin
			n = 3'd4;
		end
		return n;
	endfunction

	function automatic logic [3:0][7:0] utf8_bytes(input logic [20:0] cp, input logic [2:0] n);
		logic [3:0][7:0] b;
		b = '0;
		unique case (n)
			3'd1: begin
				b[0] = cp[7:0];
			end
			3'd2: begin
				b[0] = {3'b110, cp[10:6]};
				b[1] = {2'b10, cp[5:0]};
			end
			3'd3: begin
				b[0] = {4'b1110, cp[15:12]};
				b[1] = {2'b10, cp[11:6]};
				b[2] = {2'b10, cp[5:0]};
			end
			default: begin
				b[0] = {5'b11110, cp[20:18]};
				b[1] = {2'b10, cp[17:12]};
				b[2] = {2'b10, cp[11:6]};
				b[3] = {2'b10, cp[5:0]};
			end
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

### sv/ttu_conv.sv
// String state and decoding of one byte into its encoded characters.
`timescale 1ns / 1ps
`default_nettype none

module ttu_conv (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      advance,
	input  wire ttu_pkg::ttu_item_t        item,
	input  wire logic                      source_mode,
	input  wire logic [ttu_pkg::CAP_W-1:0] out_capacity,
	output ttu_pkg::ttu_res_t              res
);
	import ttu_pkg::*;

	ttu_phase_t         phase_q, phase_d;
	ttu_enc_t           enc_q, enc_d;
	logic               le_q, le_d;
	logic [7:0]         held_q, held_d;
	logic               half_q, half_d;
	logic [9:0]         hi_q, hi_d;
	logic               hs_q, hs_d;
	logic               stop_q, stop_d;
	logic [CAP_W-1:0]   wc_q, wc_d;

	logic [CAP_W-1:0]   cap;
	ttu_char_t          ca, cb, cc;
	logic [CAP_W-1:0]   wc_end;

	function automatic ttu_char_t put_char(input logic want, input logic raw,
			input logic [20:0] cp, input logic [CAP_W-1:0] wc, input logic [CAP_W-1:0] lim);
		ttu_char_t  c;
		logic [2:0] n;
		logic [CAP_W:0] sum;
		n       = raw ? 3'd1 : utf8_len(cp);
		sum     = {1'b0, wc} + {{(CAP_W-2){1'b0}}, n};
		c.ok    = want && (sum < {1'b0, lim});
		c.n     = c.ok ? n : 3'd0;
		c.bytes = raw ? {24'h000000, cp[7:0]} : utf8_bytes(cp, n);
		return c;
	endfunction

	assign cap = (out_capacity > CAP_LIMIT) ? CAP_LIMIT : out_capacity;

	// Next state and the characters this byte completes
	always_comb begin
		logic        cu_want, cu_done;
		logic [15:0] cu_v;
		logic        a_want, b_want, b_raw, c_want;
		logic [20:0] a_cp, b_cp;
		logic [CAP_W-1:0] wc1, wc2;

		phase_d = phase_q;
		enc_d   = enc_q;
		le_d    = le_q;
		held_d  = held_q;
		half_d  = half_q;
		hi_d    = hi_q;
		hs_d    = hs_q;
		stop_d  = stop_q;
		cu_want = 1'b0;
		cu_done = 1'b0;
		cu_v    = 16'h0000;
		a_want  = 1'b0;
		a_cp    = '0;
		b_want  = 1'b0;
		b_raw   = 1'b0;
		b_cp    = '0;

		if (item.has_byte) begin
			unique case (phase_q)
				PH_START: begin
					le_d = 1'b0;
					if (source_mode) begin
						enc_d   = ENC_CP1251;
						phase_d = PH_BODY;
						if (item.data == 8'h00) begin
							stop_d = 1'b1;
						end else begin
							b_want = 1'b1;
							b_cp   = {5'b0, cp1251_map(item.data)};
						end
					end else begin
						enc_d   = (item.data <= 8'd3) ? ttu_enc_t'(item.data[2:0]) : ENC_NONE;
						phase_d = (ttu_enc_t'(item.data[2:0]) == ENC_UTF16 && item.data[7:3] == 5'd0)
							? PH_BOM1 : PH_BODY;
					end
				end
				PH_BOM1: begin
					held_d  = item.data;
					phase_d = PH_BOM2;
				end
				PH_BOM2: begin
					phase_d = PH_BODY;
					le_d    = (held_q == BOM_FF) && (item.data == BOM_FE);
					if (!((held_q == BOM_FF && item.data == BOM_FE) ||
							(held_q == BOM_FE && item.data == BOM_FF))) begin
						cu_want = 1'b1;
						cu_v    = {held_q, item.data};
					end
				end
				default: begin
					if (!stop_q) begin
						unique case (enc_q)
							ENC_LATIN1, ENC_CP1251: begin
								if (item.data == 8'h00) begin
									stop_d = 1'b1;
								end else begin
									b_want = 1'b1;
									b_cp   = (enc_q == ENC_CP1251) ? {5'b0, cp1251_map(item.data)}
										: {13'b0, item.data};
								end
							end
							ENC_UTF16, ENC_UTF16BE: begin
								if (!half_q) begin
									held_d = item.data;
									half_d = 1'b1;
								end else begin
									half_d  = 1'b0;
									cu_want = 1'b1;
									cu_v    = le_q ? {item.data, held_q} : {held_q, item.data};
								end
							end
							ENC_UTF8: begin
								if (item.data == 8'h00) begin
									stop_d = 1'b1;
								end else begin
									b_want = 1'b1;
									b_raw  = 1'b1;
									b_cp   = {13'b0, item.data};
								end
							end
							default: begin
							end
						endcase
					end
				end
			endcase
		end

		// A held high surrogate either pairs with this unit or goes out alone
		if (cu_want && hs_q) begin
			hs_d   = 1'b0;
			hi_d   = '0;
			a_want = 1'b1;
			if (cu_v[15:10] == LOW_SURR_TAG) begin
				a_cp    = SUPP_BASE + {1'b0, hi_q, cu_v[9:0]};
				cu_done = 1'b1;
			end else begin
				a_cp = HIGH_SURR_BASE + {11'b0, hi_q};
			end
		end
		ca  = put_char(a_want, 1'b0, a_cp, wc_q, cap);
		wc1 = wc_q + {{(CAP_W-3){1'b0}}, ca.n};
		if (a_want && !ca.ok) begin
			stop_d  = 1'b1;
			cu_done = 1'b1;
		end

		if (cu_want && !cu_done) begin
			priority if (cu_v == 16'h0000) begin
				stop_d = 1'b1;
			end else if (cu_v[15:10] == HIGH_SURR_TAG) begin
				hi_d = cu_v[9:0];
				hs_d = 1'b1;
			end else begin
				b_want = 1'b1;
				b_cp   = {5'b0, cu_v};
			end
		end
		cb  = put_char(b_want, b_raw, b_cp, wc1, cap);
		wc2 = wc1 + {{(CAP_W-3){1'b0}}, cb.n};
		if (b_want && !cb.ok) begin
			stop_d = 1'b1;
		end

		// End of string: flush a lone high surrogate, then clear
		c_want = item.last && hs_d && !stop_d;
		cc     = put_char(c_want, 1'b0, HIGH_SURR_BASE + {11'b0, hi_d}, wc2, cap);
		wc_end = wc2 + {{(CAP_W-3){1'b0}}, cc.n};
		wc_d   = wc2;
		if (item.last) begin
			phase_d = PH_START;
			enc_d   = ENC_LATIN1;
			le_d    = 1'b0;
			held_d  = 8'h00;
			half_d  = 1'b0;
			hi_d    = '0;
			hs_d    = 1'b0;
			stop_d  = 1'b0;
			wc_d    = '0;
		end
	end

	// Pack the characters and the end word into one result list
	always_comb begin
		logic [3:0] e_a, e_b, e_c, kk, total;
		e_a   = {1'b0, ca.n};
		e_b   = e_a + {1'b0, cb.n};
		e_c   = e_b + {1'b0, cc.n};
		total = e_c + {3'b0, item.last};
		kk    = '0;
		for (int k = 0; k < RES_DEPTH; k++) begin
			kk = 4'(k);
			priority if (kk < e_a) begin
				res.bytes[k] = ca.bytes[2'(kk)];
			end else if (kk < e_b) begin
				res.bytes[k] = cb.bytes[2'(kk - e_a)];
			end else if (kk < e_c) begin
				res.bytes[k] = cc.bytes[2'(kk - e_b)];
			end else begin
				res.bytes[k] = 8'h00;
			end
		end
		res.count      = RES_CNT_W'(total);
		res.term       = item.last;
		res.byte_count = wc_end[COUNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			enc_q   <= ENC_LATIN1;
			le_q    <= 1'b0;
			held_q  <= 8'h00;
			half_q  <= 1'b0;
			hi_q    <= '0;
			hs_q    <= 1'b0;
			stop_q  <= 1'b0;
			wc_q    <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			enc_q   <= enc_d;
			le_q    <= le_d;
			held_q  <= held_d;
			half_q  <= half_d;
			hi_q    <= hi_d;
			hs_q    <= hs_d;
			stop_q  <= stop_d;
			wc_q    <= wc_d;
		end
	end

	a_surr_enc: assert property (@(posedge clk) disable iff (!arst_n)
		hs_q |-> (enc_q == ENC_UTF16 || enc_q == ENC_UTF16BE))
		else $error("high surrogate held outside a UTF-16 string");

	a_wc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wc_q < CAP_LIMIT)
		else $error("written count beyond capacity limit");

endmodule

`default_nettype wire

### sv/ttu_emit.sv
// Result buffer that hands out one item's words one per cycle while out_ready is high.
`timescale 1ns / 1ps
`default_nettype none

module ttu_emit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        load,
	input  wire ttu_pkg::ttu_res_t           res,
	output logic                             free,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [7:0]                       out_byte,
	output logic                             is_terminator,
	output logic                             run_last,
	output logic [ttu_pkg::COUNT_W-1:0]      byte_count
);
	import ttu_pkg::*;

	logic [RES_DEPTH-1:0][7:0] buf_q;
	logic [RES_CNT_W-1:0]      cnt_q;
	logic [RES_CNT_W-1:0]      idx_q;
	logic                      term_q;
	logic [COUNT_W-1:0]        bc_q;
	logic                      valid_q;
	logic                      last_entry;

	assign last_entry = (idx_q == cnt_q - RES_CNT_W'(1));
	assign free       = !valid_q || (out_ready && last_entry);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
			cnt_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
			cnt_q   <= res.count;
		end else if (valid_q && out_ready) begin
			if (last_entry) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + RES_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q  <= res.bytes;
			term_q <= res.term;
			bc_q   <= res.byte_count;
		end
	end

	assign out_valid     = valid_q;
	assign out_byte      = buf_q[idx_q];
	assign run_last      = last_entry;
	assign is_terminator = term_q && last_entry;
	assign byte_count    = (term_q && last_entry) ? bc_q : '0;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (cnt_q != '0 && idx_q < cnt_q))
		else $error("result index outside the held list");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("result list loaded over words not yet taken");

	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && out_ready && !last_entry) |=> (valid_q && idx_q == $past(idx_q) + RES_CNT_W'(1)))
		else $error("result index failed to advance");

endmodule

`default_nettype wire

### sv/text_to_utf8_transcoder.sv
// Top level of the text to UTF-8 transcoder: configuration, input register and wiring.
//
// Usage: a string arrives on the input channel (in_valid/in_ready) one byte per word,
// with last set on its final word; has_byte low marks a word with no byte. Each input
// word produces zero to seven result words on the output channel (out_valid/out_ready):
// UTF-8 bytes, then on the string's last word a terminator word carrying byte_count.
// run_last flags the final result word of each input word.
// Configuration (cfg_valid/cfg_ready, always ready) writes source_mode (index 0) and
// out_capacity (index 1); write it only while no results are outstanding.
// Path: an accepted word waits in the input register until the result buffer is free,
// is decoded in a single pass, and its result words are registered in that buffer.
// Throughput: one input word per cycle while each produces at most one result and
// out_ready stays high; a word with more results holds the result buffer until all
// are taken, as the output channel moves one byte per cycle while out_ready is high.
// Reset: clears the string state, returns source_mode to frame mode and the capacity to
// 256; nothing is presented until a word arrives.
// Stall: when out_ready is low the result buffer holds, the input register fills and
// in_ready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module text_to_utf8_transcoder (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [7:0]                    in_byte,
	input  wire logic                          has_byte,
	input  wire logic                          last,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [7:0]                         out_byte,
	output logic                               is_terminator,
	output logic                               run_last,
	output logic [ttu_pkg::COUNT_W-1:0]        byte_count,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [ttu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ttu_pkg::CAP_W-1:0]     cfg_data
);
	import ttu_pkg::*;

	logic             source_mode_q;
	logic [CAP_W-1:0] out_capacity_q;

	ttu_item_t        item_s1;
	logic             valid_s1;
	logic             advance;
	logic             emit_free;
	ttu_res_t         res;

	// Configuration registers: always ready, index selects the register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_mode_q  <= 1'b0;
			out_capacity_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SOURCE_MODE:  source_mode_q  <= cfg_data[0];
				CFG_OUT_CAPACITY: out_capacity_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Advance the held word once the result buffer can take its results
	assign advance  = valid_s1 && emit_free;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload needs no reset; hold it until the next word is taken
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.data     <= in_byte;
			item_s1.has_byte <= has_byte;
			item_s1.last     <= last;
		end
	end

	ttu_conv u_conv (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.item         (item_s1),
		.source_mode  (source_mode_q),
		.out_capacity (out_capacity_q),
		.res          (res)
	);

	// Drop words that produce nothing; load the rest into the result buffer
	ttu_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (advance && (res.count != '0)),
		.res           (res),
		.free          (emit_free),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.is_terminator (is_terminator),
		.run_last      (run_last),
		.byte_count    (byte_count)
	);

endmodule

`default_nettype wire
